// ----- hw/rtl/mie_pkg.sv -----
// Shared opcodes, status codes, access sizes and the per-word control record
// for the I-type execute block. No dependencies.
`default_nettype none

package mie_pkg;

    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_SLTI  = 6'd10;
    localparam logic [5:0] OP_SLTIU = 6'd11;
    localparam logic [5:0] OP_ANDI  = 6'd12;
    localparam logic [5:0] OP_ORI   = 6'd13;
    localparam logic [5:0] OP_XORI  = 6'd14;
    localparam logic [5:0] OP_LUI   = 6'd15;
    localparam logic [5:0] OP_LB    = 6'd32;
    localparam logic [5:0] OP_LH    = 6'd33;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_LBU   = 6'd36;
    localparam logic [5:0] OP_LHU   = 6'd37;
    localparam logic [5:0] OP_SB    = 6'd40;
    localparam logic [5:0] OP_SW    = 6'd43;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVF     = 2'd1;
    localparam logic [1:0] ST_ADDR    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // What the retire stage needs to finish one word.
    typedef struct packed {
        logic        is_load;
        logic [1:0]  size;
        logic        sign;
        logic [1:0]  offset;
        logic [31:0] result;
        logic        write_result;
        logic [1:0]  status;
    } pend_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mie_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module mie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mie_issue.sv -----
// Issue stage: decodes the opcode, works out ALU results and the effective
// address, checks it, and drives the four byte-lane RAMs. Uses mie_pkg.
`default_nettype none

module mie_issue #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  wire logic                     fire,
    input  wire logic [5:0]               mode,
    input  wire logic [31:0]              source_value,
    input  wire logic [31:0]              store_value,
    input  wire logic signed [15:0]       immediate,
    output mie_pkg::pend_t                info,
    output logic                          mem_read,
    output logic [3:0]                    lane_we,
    output logic [MEM_ADDR_BITS-3:0]      word_addr,
    output logic [31:0]                   wdata
);

    logic [31:0] simm;
    logic [31:0] zimm;
    logic [31:0] ea;
    logic        in_range;
    logic        ovf;
    logic [3:0]  lane_sel;
    mie_pkg::pend_t info_c;

    always_comb
    begin
        simm     = {{16{immediate[15]}}, immediate};
        zimm     = {16'h0000, immediate};
        ea       = source_value + simm;
        in_range = (ea[31:MEM_ADDR_BITS] == '0);
        ovf      = (~(source_value[31] ^ simm[31])) & (source_value[31] ^ ea[31]);
        lane_sel = 4'b0000;
        wdata    = store_value;

        info_c.is_load      = 1'b0;
        info_c.size         = mie_pkg::SZ_BYTE;
        info_c.sign         = 1'b0;
        info_c.offset       = ea[1:0];
        info_c.result       = 32'h0;
        info_c.write_result = 1'b0;
        info_c.status       = mie_pkg::ST_OK;

        case (mode)
            mie_pkg::OP_ADDI:
            begin
                if (ovf)
                begin
                    info_c.status = mie_pkg::ST_OVF;
                end
                else
                begin
                    info_c.result       = ea;
                    info_c.write_result = 1'b1;
                end
            end
            mie_pkg::OP_ADDIU:
            begin
                info_c.result       = ea;
                info_c.write_result = 1'b1;
            end
            mie_pkg::OP_SLTI:
            begin
                info_c.result       = {31'h0, ($signed(source_value) < $signed(simm))};
                info_c.write_result = 1'b1;
            end
            mie_pkg::OP_SLTIU:
            begin
                info_c.result       = {31'h0, (source_value < simm)};
                info_c.write_result = 1'b1;
            end
            mie_pkg::OP_ANDI:
            begin
                info_c.result       = source_value & zimm;
                info_c.write_result = 1'b1;
            end
            mie_pkg::OP_ORI:
            begin
                info_c.result       = source_value | zimm;
                info_c.write_result = 1'b1;
            end
            mie_pkg::OP_XORI:
            begin
                info_c.result       = source_value ^ zimm;
                info_c.write_result = 1'b1;
            end
            mie_pkg::OP_LUI:
            begin
                info_c.result       = {immediate, 16'h0000};
                info_c.write_result = 1'b1;
            end
            mie_pkg::OP_LB, mie_pkg::OP_LBU:
            begin
                info_c.size = mie_pkg::SZ_BYTE;
                info_c.sign = (mode == mie_pkg::OP_LB);
                if (in_range)
                begin
                    info_c.is_load      = 1'b1;
                    info_c.write_result = 1'b1;
                end
                else
                begin
                    info_c.status = mie_pkg::ST_ADDR;
                end
            end
            mie_pkg::OP_LH, mie_pkg::OP_LHU:
            begin
                info_c.size = mie_pkg::SZ_HALF;
                info_c.sign = (mode == mie_pkg::OP_LH);
                if (in_range && !ea[0])
                begin
                    info_c.is_load      = 1'b1;
                    info_c.write_result = 1'b1;
                end
                else
                begin
                    info_c.status = mie_pkg::ST_ADDR;
                end
            end
            mie_pkg::OP_LW:
            begin
                info_c.size = mie_pkg::SZ_WORD;
                if (in_range && (ea[1:0] == 2'b00))
                begin
                    info_c.is_load      = 1'b1;
                    info_c.write_result = 1'b1;
                end
                else
                begin
                    info_c.status = mie_pkg::ST_ADDR;
                end
            end
            mie_pkg::OP_SB:
            begin
                // The byte is copied to every lane; only the addressed lane writes.
                wdata = {4{store_value[7:0]}};
                if (in_range)
                begin
                    lane_sel = 4'b0001 << ea[1:0];
                end
                else
                begin
                    info_c.status = mie_pkg::ST_ADDR;
                end
            end
            mie_pkg::OP_SW:
            begin
                if (in_range && (ea[1:0] == 2'b00))
                begin
                    lane_sel = 4'b1111;
                end
                else
                begin
                    info_c.status = mie_pkg::ST_ADDR;
                end
            end
            default:
            begin
                info_c.status = mie_pkg::ST_INVALID;
            end
        endcase
    end

    assign info      = info_c;
    assign mem_read  = fire & info_c.is_load;
    assign lane_we   = fire ? lane_sel : 4'b0000;
    assign word_addr = ea[MEM_ADDR_BITS-1:2];

endmodule

`default_nettype wire

// ----- hw/rtl/mie_retire.sv -----
// Retire stage: holds the word whose RAM read is in flight, shapes load data
// (lane select, sign or zero extension) and keeps the output register. Uses mie_pkg.
`default_nettype none

module mie_retire (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire mie_pkg::pend_t info,
    input  wire logic [31:0]    rdata,
    input  wire logic           result_stall,
    output logic                busy,
    output logic                pend_valid,
    output logic                result_valid,
    output logic [31:0]         result,
    output logic                write_result,
    output logic [1:0]          status
);

    logic           pend_valid_reg;
    logic           pend_valid_next;
    mie_pkg::pend_t pend_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [31:0]    out_result_reg;
    logic           out_write_reg;
    logic [1:0]     out_status_reg;
    logic           pend_move;
    logic [7:0]     byte_sel;
    logic [15:0]    half_sel;
    logic [31:0]    loaded;
    logic [31:0]    value;

    assign pend_move       = pend_valid_reg & (~out_valid_reg | ~result_stall);
    // The RAM read data only holds while the pending word waits, so no new word
    // may enter until it has moved on.
    assign busy            = pend_valid_reg & ~pend_move;
    assign pend_valid_next = fire | (pend_valid_reg & ~pend_move);
    assign out_valid_next  = pend_move | (out_valid_reg & result_stall);

    always_comb
    begin
        case (pend_reg.offset)
            2'd0:    byte_sel = rdata[31:24];
            2'd1:    byte_sel = rdata[23:16];
            2'd2:    byte_sel = rdata[15:8];
            default: byte_sel = rdata[7:0];
        endcase
        half_sel = pend_reg.offset[1] ? rdata[15:0] : rdata[31:16];

        case (pend_reg.size)
            mie_pkg::SZ_BYTE:
                loaded = {{24{pend_reg.sign & byte_sel[7]}}, byte_sel};
            mie_pkg::SZ_HALF:
                loaded = {{16{pend_reg.sign & half_sel[15]}}, half_sel};
            default:
                loaded = rdata;
        endcase

        value = pend_reg.is_load ? loaded : pend_reg.result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pend_reg <= info;
        end
        if (pend_move)
        begin
            out_result_reg <= value;
            out_write_reg  <= pend_reg.write_result;
            out_status_reg <= pend_reg.status;
        end
    end

    assign pend_valid   = pend_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;
    assign write_result = out_write_reg;
    assign status       = out_status_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mips_itype_execute_top.sv -----
// Top level of the I-type execute block: issue stage, four byte-lane data RAMs
// and the retire stage. Uses mie_pkg, mie_issue, mie_ram and mie_retire.
//
//  Channel   Handshake                     Payload
//  instr     instr_valid / instr_stall     mode, source_value, store_value, immediate
//  result    result_valid / result_stall   result, write_result, status
//
// One word is taken per cycle while instr_stall is low; its result goes from the
// registered read of the data RAMs and the pending word register through the
// output register before it is presented on the result channel.
// Memory is four byte lanes, one access per word, read or written at the
// accepting edge, so a load directly after a store sees the stored data.
// Reset clears only control state; memory contents are undefined until written.
// instr_stall rises only when both the pending word and the output register are held.
`default_nettype none

module mips_itype_execute_top #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               instr_valid,
    output logic                    instr_stall,
    input  wire logic [5:0]         mode,
    input  wire logic [31:0]        source_value,
    input  wire logic [31:0]        store_value,
    input  wire logic signed [15:0] immediate,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [31:0]             result,
    output logic                    write_result,
    output logic [1:0]              status
);

    localparam int WORD_BITS = MEM_ADDR_BITS - 2;
    localparam int WORDS     = 1 << WORD_BITS;

    logic                  fire;
    logic                  busy;
    logic                  pend_valid;
    mie_pkg::pend_t        info;
    logic                  mem_read;
    logic [3:0]            lane_we;
    logic [WORD_BITS-1:0]  word_addr;
    logic [31:0]           wdata;
    logic [31:0]           rdata;

    assign instr_stall = busy;
    assign fire        = instr_valid & ~busy;

    mie_issue #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_issue (
        .fire         (fire),
        .mode         (mode),
        .source_value (source_value),
        .store_value  (store_value),
        .immediate    (immediate),
        .info         (info),
        .mem_read     (mem_read),
        .lane_we      (lane_we),
        .word_addr    (word_addr),
        .wdata        (wdata)
    );

    // Lane 0 holds the most significant byte of each big-endian word.
    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        mie_ram #(
            .WIDTH (8),
            .DEPTH (WORDS)
        ) u_ram (
            .clk   (clk),
            .en    (mem_read | lane_we[k]),
            .we    (lane_we[k]),
            .addr  (word_addr),
            .wdata (wdata[8*(3-k) +: 8]),
            .rdata (rdata[8*(3-k) +: 8])
        );
    end

    mie_retire u_retire (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .info         (info),
        .rdata        (rdata),
        .result_stall (result_stall),
        .busy         (busy),
        .pend_valid   (pend_valid),
        .result_valid (result_valid),
        .result       (result),
        .write_result (write_result),
        .status       (status)
    );

    a_accept_pends: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> pend_valid)
        else $error("accepted word did not enter the retire stage");

    a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pend_valid))
        else $error("result appeared without a pending word");

    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != mie_pkg::ST_OK) |-> (!write_result && result == 32'h0))
        else $error("faulting word carries a register write");

    a_no_write_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_we != 4'b0000) |-> !busy)
        else $error("memory written while input stalled");

endmodule

`default_nettype wire
